FILE: src/crcfr_pkg.sv
// Package for the CRC-16 framed receiver and acknowledgement tracker.
// Holds word types, phase and action codes, error codes and the CRC step.
// No dependencies.
package crcfr_pkg;

  localparam logic [7:0]  SyncA   = 8'hAA;
  localparam logic [7:0]  SyncB   = 8'h55;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef enum logic [1:0] {
    ACT_BYTE = 2'd0,
    ACT_SENT = 2'd1,
    ACT_TICK = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_SYNC = 3'd1,
    PH_HEAD = 3'd2,
    PH_BODY = 3'd3,
    PH_CRCL = 3'd4,
    PH_CRCH = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_MISSION = 2'd0,
    KIND_REPORT  = 2'd1,
    KIND_REJECT  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    MS_IDLE    = 3'd0,
    MS_WAIT    = 3'd1,
    MS_OK      = 3'd2,
    MS_FAIL    = 3'd3,
    MS_TIMEOUT = 3'd4
  } mstate_e;

  typedef enum logic [3:0] {
    ERR_NONE    = 4'd0,
    ERR_CRC     = 4'd1,
    ERR_ID      = 4'd2,
    ERR_ACK_LEN = 4'd3,
    ERR_ACK_SEQ = 4'd4,
    ERR_REP_LEN = 4'd5,
    ERR_CODE    = 4'd6,
    ERR_COL     = 4'd7,
    ERR_ROW     = 4'd8,
    ERR_COUNT   = 4'd9
  } err_e;

  typedef enum logic [1:0] {
    REG_MAX_LEN = 2'd0,
    REG_ACK_ID  = 2'd1,
    REG_REP_ID  = 2'd2,
    REG_TIMEOUT = 2'd3
  } reg_e;

  localparam int CfgIdxW = 2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic [7:0] sent_seq;
    logic [7:0] sent_points;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  mission_state;
    logic [15:0] point_total;
    logic [3:0]  error_code;
    logic [7:0]  species_code;
    logic [7:0]  grid_col;
    logic [7:0]  grid_row;
    logic [7:0]  animal_count;
    logic [7:0]  frame_seq;
  } out_word_t;

  // Front to back command: frame end or tracker event.
  typedef struct packed {
    logic [1:0]  action;
    logic        frame_end;
    logic        crc_ok;
    logic [7:0]  msg_id;
    logic [7:0]  seq;
    logic        len_is4;
    logic [31:0] head;
    logic [7:0]  sent_seq;
    logic [7:0]  sent_points;
  } cmd_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: src/crcfr_front.sv
// Frame parser: sync hunt, header, CRC and payload capture, resync replay.
// Emits one command per frame end or tracker event. Depends on crcfr_pkg.
module crcfr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  crcfr_pkg::in_word_t in_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [15:0]         max_len_i,
  output crcfr_pkg::cmd_t     cmd_o,
  output logic                cmd_valid_o,
  input  logic                cmd_full_i
);
  import crcfr_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] idx_q, idx_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  id_q, id_d, seq_q, seq_d, crcl_q, crcl_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  head_q [4];
  logic [7:0]  rep_q [4];
  logic [2:0]  rcnt_q, rcnt_d;
  logic        replay;
  logic [7:0]  b;
  logic        take;
  logic        resync;
  logic [15:0] newlen;
  logic [15:0] idx_inc;

  assign replay     = rcnt_q != 3'd0;
  assign in_stall_o = replay || cmd_full_i;
  assign take       = in_valid_i && !in_stall_o;
  assign b          = replay ? rep_q[2'(3'd4 - rcnt_q)] : in_i.rx_byte;
  assign newlen     = {b, len_q[7:0]};
  assign idx_inc    = idx_q + 16'd1;

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    len_d   = len_q;
    id_d    = id_q;
    seq_d   = seq_q;
    crc_d   = crc_q;
    crcl_d  = crcl_q;
    resync  = 1'b0;
    if ((take && in_i.action == ACT_BYTE) || replay) begin
      unique case (phase_q)
        PH_SYNC: begin
          if (b == SyncB) begin
            phase_d = PH_HEAD;
            idx_d   = '0;
            crc_d   = CrcInit;
          end else if (b != SyncA) begin
            phase_d = PH_HUNT;
          end
        end
        PH_HEAD: begin
          crc_d = crc_step(crc_q, b);
          idx_d = idx_inc;
          unique case (idx_q[1:0])
            2'd0: id_d  = b;
            2'd1: seq_d = b;
            2'd2: len_d = {8'h00, b};
            default: begin
              len_d = newlen;
              idx_d = '0;
              if (newlen > max_len_i) begin
                phase_d = PH_HUNT;
                resync  = !replay;
              end else begin
                phase_d = (newlen == 16'd0) ? PH_CRCL : PH_BODY;
              end
            end
          endcase
        end
        PH_BODY: begin
          crc_d = crc_step(crc_q, b);
          idx_d = idx_inc;
          if (idx_inc >= len_q) phase_d = PH_CRCL;
        end
        PH_CRCL: begin
          crcl_d  = b;
          phase_d = PH_CRCH;
        end
        PH_CRCH: phase_d = PH_HUNT;
        default: phase_d = (b == SyncA) ? PH_SYNC : PH_HUNT;
      endcase
    end
  end

  always_comb begin
    rcnt_d = rcnt_q;
    if (replay) rcnt_d = rcnt_q - 3'd1;
    else if (resync) rcnt_d = 3'd4;
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.action      = in_i.action;
    cmd_o.frame_end   = in_i.action == ACT_BYTE;
    cmd_o.crc_ok      = {in_i.rx_byte, crcl_q} == crc_q;
    cmd_o.msg_id      = id_q;
    cmd_o.seq         = seq_q;
    cmd_o.len_is4     = len_q == 16'd4;
    cmd_o.head        = {head_q[3], head_q[2], head_q[1], head_q[0]};
    cmd_o.sent_seq    = in_i.sent_seq;
    cmd_o.sent_points = in_i.sent_points;
    cmd_valid_o = take && ((in_i.action == ACT_BYTE && phase_q == PH_CRCH)
                  || in_i.action == ACT_SENT || in_i.action == ACT_TICK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      idx_q   <= '0;
      len_q   <= '0;
      id_q    <= '0;
      seq_q   <= '0;
      crc_q   <= CrcInit;
      crcl_q  <= '0;
      rcnt_q  <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
      id_q    <= id_d;
      seq_q   <= seq_d;
      crc_q   <= crc_d;
      crcl_q  <= crcl_d;
      rcnt_q  <= rcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((take && in_i.action == ACT_BYTE) || replay) begin
      if (phase_q == PH_HEAD) rep_q[idx_q[1:0]] <= b;
      if (phase_q == PH_BODY && idx_q < 16'd4) head_q[idx_q[1:0]] <= b;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    resync |=> rcnt_q == 3'd4) else $error("replay not started");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    replay |-> in_stall_o) else $error("input taken during replay");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    replay |-> !cmd_valid_o) else $error("command during replay");
endmodule

FILE: src/crcfr_queue.sv
// Two-entry command queue between parser and tracker.
// Depends on crcfr_pkg.
module crcfr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  crcfr_pkg::cmd_t wr_i,
  input  logic            wr_valid_i,
  output logic            full_o,
  output crcfr_pkg::cmd_t rd_o,
  output logic            rd_valid_o,
  input  logic            rd_take_i
);
  import crcfr_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_o       = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr_valid_i) wp_q <= ~wp_q;
      if (rd_take_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr_valid_i} - {1'b0, rd_take_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_valid_i) mem_q[wp_q] <= wr_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !wr_valid_i) else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_take_i |-> rd_valid_o) else $error("queue underflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
endmodule

FILE: src/crcfr_back.sv
// Ack tracker and frame dispatcher with registered output word.
// Depends on crcfr_pkg.
module crcfr_back #(
  parameter int TimerBits = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  crcfr_pkg::cmd_t      cmd_i,
  input  logic                 cmd_valid_i,
  output logic                 cmd_take_o,
  input  logic [7:0]           ack_id_i,
  input  logic [7:0]           rep_id_i,
  input  logic [15:0]          timeout_i,
  output crcfr_pkg::out_word_t out_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i
);
  import crcfr_pkg::*;

  logic                 wait_q, wait_d;
  logic [7:0]           wseq_q, wseq_d, wpts_q, wpts_d;
  logic [TimerBits-1:0] el_q, el_d;
  out_word_t            res_q, res_d;
  logic                 ov_q, emit;
  logic [7:0]           h0, h1, h2, h3;

  assign out_o       = res_q;
  assign out_valid_o = ov_q;
  assign cmd_take_o  = cmd_valid_i && (!ov_q || !out_stall_i);
  assign {h3, h2, h1, h0} = cmd_i.head;

  always_comb begin
    wait_d = wait_q;
    wseq_d = wseq_q;
    wpts_d = wpts_q;
    el_d   = el_q;
    res_d  = '0;
    res_d.frame_seq = cmd_i.seq;
    emit   = 1'b0;
    unique case (action_e'(cmd_i.action))
      ACT_SENT: begin
        wait_d = 1'b1;
        wseq_d = cmd_i.sent_seq;
        wpts_d = cmd_i.sent_points;
        el_d   = '0;
        emit   = 1'b1;
        res_d.kind          = KIND_MISSION;
        res_d.mission_state = MS_WAIT;
        res_d.point_total   = {8'h00, cmd_i.sent_points};
        res_d.frame_seq     = cmd_i.sent_seq;
      end
      ACT_TICK: begin
        if (wait_q) begin
          if (el_q != '1) el_d = el_q + 1'b1;
          if (32'(el_d) > {16'h0000, timeout_i}) begin
            wait_d = 1'b0;
            emit   = 1'b1;
            res_d.kind          = KIND_MISSION;
            res_d.mission_state = MS_TIMEOUT;
            res_d.point_total   = {8'h00, wpts_q};
            res_d.frame_seq     = wseq_q;
          end
        end
      end
      ACT_BYTE: begin
        emit = 1'b1;
        res_d.kind = KIND_REJECT;
        if (!cmd_i.crc_ok) begin
          res_d.error_code = ERR_CRC;
        end else if (cmd_i.msg_id == ack_id_i) begin
          if (!cmd_i.len_is4) res_d.error_code = ERR_ACK_LEN;
          else if (!wait_q) emit = 1'b0;
          else if (cmd_i.seq != wseq_q) res_d.error_code = ERR_ACK_SEQ;
          else begin
            res_d.kind          = KIND_MISSION;
            res_d.mission_state = (h0 == 8'd0) ? MS_OK : MS_FAIL;
            res_d.point_total   = {h3, h2};
            wait_d = 1'b0;
          end
        end else if (cmd_i.msg_id == rep_id_i) begin
          if (!cmd_i.len_is4) res_d.error_code = ERR_REP_LEN;
          else if (h0 > 8'd4) res_d.error_code = ERR_CODE;
          else if (h1 < 8'd1 || h1 > 8'd9) res_d.error_code = ERR_COL;
          else if (h2 < 8'd1 || h2 > 8'd7) res_d.error_code = ERR_ROW;
          else if (h3 < 8'd1) res_d.error_code = ERR_COUNT;
          else begin
            res_d.kind         = KIND_REPORT;
            res_d.species_code = h0;
            res_d.grid_col     = h1;
            res_d.grid_row     = h2;
            res_d.animal_count = h3;
          end
        end else begin
          res_d.error_code = ERR_ID;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q <= 1'b0;
      wseq_q <= '0;
      wpts_q <= '0;
      el_q   <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (cmd_take_o) begin
        wait_q <= wait_d;
        wseq_q <= wseq_d;
        wpts_q <= wpts_d;
        el_q   <= el_d;
        ov_q   <= emit;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) res_q <= res_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_stall_i |=> ov_q && $stable(res_q)) else $error("result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take_o && cmd_i.action == ACT_SENT |=> wait_q) else $error("wait not started");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wait_q && cmd_take_o && cmd_i.action == ACT_TICK |=> !ov_q)
    else $error("tick result while idle");
endmodule

FILE: src/crc16_frame_receiver_ack_tracker.sv
// Top level: CRC-16/Modbus framed receiver with acknowledgement tracking.
// A result word is registered in the tracker after its command has passed through the queue.
// Throughput: one word per cycle while the queue has room; an oversized length
// stalls the input while the parser replays the four header bytes.
// Reset: asynchronous, active low; registers return to their listed values.
// Depends on crcfr_pkg, crcfr_front, crcfr_queue and crcfr_back.
module crc16_frame_receiver_ack_tracker #(
  parameter int TIMER_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  crcfr_pkg::in_word_t  in_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output crcfr_pkg::out_word_t out_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i
);
  import crcfr_pkg::*;

  logic [15:0] max_len_q, tmo_q;
  logic [7:0]  ack_id_q, rep_id_q;
  cmd_t        fcmd, qcmd;
  logic        fvalid, qfull, qvalid, qtake;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= 16'd2048;
      ack_id_q  <= 8'd129;
      rep_id_q  <= 8'd2;
      tmo_q     <= 16'd500;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_MAX_LEN: max_len_q <= cfg_data_i;
        REG_ACK_ID:  ack_id_q  <= cfg_data_i[7:0];
        REG_REP_ID:  rep_id_q  <= cfg_data_i[7:0];
        default:     tmo_q     <= cfg_data_i;
      endcase
    end
  end

  crcfr_front u_front (
    .clk_i, .rst_ni, .in_i, .in_valid_i, .in_stall_o,
    .max_len_i(max_len_q), .cmd_o(fcmd), .cmd_valid_o(fvalid), .cmd_full_i(qfull)
  );

  crcfr_queue u_queue (
    .clk_i, .rst_ni, .wr_i(fcmd), .wr_valid_i(fvalid), .full_o(qfull),
    .rd_o(qcmd), .rd_valid_o(qvalid), .rd_take_i(qtake)
  );

  crcfr_back #(.TimerBits(TIMER_BITS)) u_back (
    .clk_i, .rst_ni, .cmd_i(qcmd), .cmd_valid_i(qvalid), .cmd_take_o(qtake),
    .ack_id_i(ack_id_q), .rep_id_i(rep_id_q), .timeout_i(tmo_q),
    .out_o, .out_valid_o, .out_stall_i
  );
endmodule
